@@ rtl/cross_spectrum_accumulator_top_defines.svh @@
`ifndef CROSS_SPECTRUM_ACCUMULATOR_TOP_DEFINES_SVH
`define CROSS_SPECTRUM_ACCUMULATOR_TOP_DEFINES_SVH

// Checked on rising clock, off while reset is high.
`define CSA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on rising clock, reset cycles included.
`define CSA_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/csa_pkg.sv @@
package csa_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int ACC_W     = 48;
   localparam int BIN_W     = 7;
   localparam int NUM_BINS  = 128;
   localparam int NUM_CROSS = 4;
   localparam int PROD_W    = 2 * SAMPLE_W;
   localparam int TERM_W    = PROD_W + 1;
   // power of two, so queue pointers wrap on their own
   localparam int QDEPTH    = 4;
   localparam int QIDX_W    = $clog2(QDEPTH);
   localparam int OCC_W     = $clog2(QDEPTH + 1);
   localparam int POWER_W   = ACC_W - 1;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [PROD_W-1:0]   prod_type;
   typedef logic signed [TERM_W-1:0]   term_type;
   typedef logic [ACC_W-1:0]           acc_type;

   typedef struct packed {
      logic [BIN_W-1:0] bin_index;
      logic             start_flag;
      sample_type       ref_real;
      sample_type       ref_imag;
      sample_type       ch1_real;
      sample_type       ch1_imag;
      sample_type       ch2_real;
      sample_type       ch2_imag;
      sample_type       ch3_real;
      sample_type       ch3_imag;
      sample_type       ch4_real;
      sample_type       ch4_imag;
   } req_word_type;

   typedef struct packed {
      logic [BIN_W-1:0]         out_bin;
      logic [POWER_W-1:0]       ref_power_sum;
      logic signed [ACC_W-1:0]  cross1_real_sum;
      logic signed [ACC_W-1:0]  cross1_imag_sum;
      logic signed [ACC_W-1:0]  cross2_real_sum;
      logic signed [ACC_W-1:0]  cross2_imag_sum;
      logic signed [ACC_W-1:0]  cross3_real_sum;
      logic signed [ACC_W-1:0]  cross3_imag_sum;
      logic signed [ACC_W-1:0]  cross4_real_sum;
      logic signed [ACC_W-1:0]  cross4_imag_sum;
   } rsp_word_type;

   // one classified item: bin, clear request and the product terms to add
   typedef struct packed {
      logic [BIN_W-1:0]               bin_index;
      logic                           start_flag;
      term_type                       power_term;
      logic [NUM_CROSS-1:0][TERM_W-1:0] cross_re;
      logic [NUM_CROSS-1:0][TERM_W-1:0] cross_im;
   } work_type;

   // all sums of one bin
   typedef struct packed {
      acc_type                         power;
      logic [NUM_CROSS-1:0][ACC_W-1:0] cross_re;
      logic [NUM_CROSS-1:0][ACC_W-1:0] cross_im;
   } row_type;

   typedef enum logic {
      ST_IDLE,
      ST_UPDATE
   } back_state_type;

   function automatic acc_type sat_add(input acc_type acc, input logic [TERM_W-1:0] term);
      logic [ACC_W:0] sum;
      acc_type        res;
      sum = {acc[ACC_W-1], acc} + {{(ACC_W + 1 - TERM_W){term[TERM_W-1]}}, term};
      if (sum[ACC_W] != sum[ACC_W-1]) begin
         res = sum[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}} : {1'b0, {(ACC_W - 1){1'b1}}};
      end else begin
         res = sum[ACC_W-1:0];
      end
      return res;
   endfunction

endpackage

@@ rtl/csa_channels.sv @@
interface csa_req_if import csa_pkg::*; ();
   logic         valid;
   logic         ready;
   req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface csa_rsp_if import csa_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ rtl/cross_spectrum_accumulator_top.sv @@
// Cross power spectrum accumulator.
// req_bus carries one word per FFT bin: bin index, start flag and the Q1.15
// complex values of the reference channel and four further channels. A word
// is taken at a rising clock edge with valid and ready both high.
// A start flag of zero clears every bin before the addressed bin is updated.
// rsp_bus returns one word per request, in order: the bin index, the running
// power of the reference channel (47 bits) and the four running cross sums
// (signed 48 bits), all saturating integers of the raw products.
// The back end reads and then writes a bin row in the single accumulator
// memory, so it takes the next word only once the last row is written.
// Front end: input register, product register and term register feeding a
// 4-entry queue; req_ready drops while 4 words are in flight.
// Reset (synchronous) empties the pipeline and clears the 128 per-bin valid
// bits, so all bins read as zero at once; no clearing pass is needed.
// When the receiver stalls, the response register holds its word, the back
// end stops, the queue fills and req_ready falls.
module cross_spectrum_accumulator_top import csa_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   csa_req_if.sink   req_bus,
   csa_rsp_if.source rsp_bus
);

   logic     push_valid;
   work_type push_word;
   logic     q_valid;
   work_type q_head;
   logic     q_pop;

   csa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .q_pop      (q_pop),
      .push_valid (push_valid),
      .push_word  (push_word)
   );

   csa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_word  (push_word),
      .q_pop      (q_pop),
      .q_valid    (q_valid),
      .q_head     (q_head)
   );

   csa_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_head  (q_head),
      .q_pop   (q_pop),
      .rsp_bus (rsp_bus)
   );

endmodule

@@ rtl/csa_front.sv @@
module csa_front import csa_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   csa_req_if.sink  req_bus,
   input  logic     q_pop,
   output logic     push_valid,
   output work_type push_word
);

   logic             accept;
   logic [OCC_W-1:0] occ_ff, occ_in;

   logic         a_vld_ff;
   req_word_type a_word_ff;

   logic             b_vld_ff;
   logic [BIN_W-1:0] b_bin_ff;
   logic             b_start_ff;
   prod_type         b_rr_ff, b_ii_ff;
   prod_type         b_crr_ff [NUM_CROSS];
   prod_type         b_cii_ff [NUM_CROSS];
   prod_type         b_cir_ff [NUM_CROSS];
   prod_type         b_cri_ff [NUM_CROSS];
   prod_type         b_crr_in [NUM_CROSS];
   prod_type         b_cii_in [NUM_CROSS];
   prod_type         b_cir_in [NUM_CROSS];
   prod_type         b_cri_in [NUM_CROSS];

   logic     c_vld_ff;
   work_type c_word_ff, c_word_in;

   sample_type ch_re [NUM_CROSS];
   sample_type ch_im [NUM_CROSS];

   // items in the three stages plus the queue never exceed the queue depth
   assign req_bus.ready = (occ_ff < OCC_W'(QDEPTH));
   assign accept        = req_bus.valid && req_bus.ready;
   assign occ_in        = occ_ff + OCC_W'(accept) - OCC_W'(q_pop);

   assign ch_re[0] = a_word_ff.ch1_real;
   assign ch_im[0] = a_word_ff.ch1_imag;
   assign ch_re[1] = a_word_ff.ch2_real;
   assign ch_im[1] = a_word_ff.ch2_imag;
   assign ch_re[2] = a_word_ff.ch3_real;
   assign ch_im[2] = a_word_ff.ch3_imag;
   assign ch_re[3] = a_word_ff.ch4_real;
   assign ch_im[3] = a_word_ff.ch4_imag;

   always_comb begin
      for (int i = 0; i < NUM_CROSS; i++) begin
         b_crr_in[i] = ch_re[i] * a_word_ff.ref_real;
         b_cii_in[i] = ch_im[i] * a_word_ff.ref_imag;
         b_cir_in[i] = ch_im[i] * a_word_ff.ref_real;
         b_cri_in[i] = ch_re[i] * a_word_ff.ref_imag;
      end
   end

   always_comb begin
      c_word_in.bin_index  = b_bin_ff;
      c_word_in.start_flag = b_start_ff;
      c_word_in.power_term = {b_rr_ff[PROD_W-1], b_rr_ff} + {b_ii_ff[PROD_W-1], b_ii_ff};
      for (int i = 0; i < NUM_CROSS; i++) begin
         c_word_in.cross_re[i] = {b_crr_ff[i][PROD_W-1], b_crr_ff[i]}
                               + {b_cii_ff[i][PROD_W-1], b_cii_ff[i]};
         c_word_in.cross_im[i] = {b_cir_ff[i][PROD_W-1], b_cir_ff[i]}
                               - {b_cri_ff[i][PROD_W-1], b_cri_ff[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff   <= '0;
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
      end else begin
         occ_ff   <= occ_in;
         a_vld_ff <= accept;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_word_ff  <= req_bus.data;
      b_bin_ff   <= a_word_ff.bin_index;
      b_start_ff <= a_word_ff.start_flag;
      b_rr_ff    <= a_word_ff.ref_real * a_word_ff.ref_real;
      b_ii_ff    <= a_word_ff.ref_imag * a_word_ff.ref_imag;
      b_crr_ff   <= b_crr_in;
      b_cii_ff   <= b_cii_in;
      b_cir_ff   <= b_cir_in;
      b_cri_ff   <= b_cri_in;
      c_word_ff  <= c_word_in;
   end

   assign push_valid = c_vld_ff;
   assign push_word  = c_word_ff;

endmodule

@@ rtl/csa_queue.sv @@
module csa_queue import csa_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   input  work_type push_word,
   input  logic     q_pop,
   output logic     q_valid,
   output work_type q_head
);

   work_type          slot_ff [QDEPTH];
   logic [QIDX_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [OCC_W-1:0]  count_ff;

   assign q_valid = (count_ff != '0);
   assign q_head  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_valid) begin
            wr_ptr_ff <= wr_ptr_ff + QIDX_W'(1);
         end
         if (q_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QIDX_W'(1);
         end
         count_ff <= count_ff + OCC_W'(push_valid) - OCC_W'(q_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

@@ rtl/csa_back.sv @@
module csa_back import csa_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      q_valid,
   input  work_type  q_head,
   output logic      q_pop,
   csa_rsp_if.source rsp_bus
);

   back_state_type      state_ff, state_in;
   work_type            work_ff, work_in;
   logic                live_ff, live_in;
   logic [NUM_BINS-1:0] valid_ff, valid_in;
   logic                rsp_vld_ff, rsp_vld_in;
   rsp_word_type        rsp_data_ff, rsp_data_in;

   row_type mem [NUM_BINS];
   row_type rd_row_ff;
   row_type old_row, new_row;
   logic    mem_re, mem_we;
   logic    in_range;

   assign in_range = (int'(work_ff.bin_index) < NUM_BINS);
   assign old_row  = live_ff ? rd_row_ff : '0;

   always_comb begin
      new_row.power = sat_add(old_row.power, work_ff.power_term);
      for (int i = 0; i < NUM_CROSS; i++) begin
         new_row.cross_re[i] = sat_add(old_row.cross_re[i], work_ff.cross_re[i]);
         new_row.cross_im[i] = sat_add(old_row.cross_im[i], work_ff.cross_im[i]);
      end
   end

   always_comb begin
      state_in    = state_ff;
      work_in     = work_ff;
      live_in     = live_ff;
      valid_in    = valid_ff;
      q_pop       = 1'b0;
      mem_re      = 1'b0;
      mem_we      = 1'b0;
      rsp_vld_in  = rsp_vld_ff && !rsp_bus.ready;
      rsp_data_in = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid && (!rsp_vld_ff || rsp_bus.ready)) begin
               q_pop    = 1'b1;
               mem_re   = 1'b1;
               work_in  = q_head;
               live_in  = q_head.start_flag && valid_ff[q_head.bin_index];
               if (!q_head.start_flag) begin
                  valid_in = '0;
               end
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            mem_we      = in_range;
            if (in_range) begin
               valid_in[work_ff.bin_index] = 1'b1;
            end
            rsp_vld_in  = 1'b1;
            rsp_data_in = '0;
            rsp_data_in.out_bin = work_ff.bin_index;
            if (in_range) begin
               rsp_data_in.ref_power_sum   = new_row.power[POWER_W-1:0];
               rsp_data_in.cross1_real_sum = new_row.cross_re[0];
               rsp_data_in.cross1_imag_sum = new_row.cross_im[0];
               rsp_data_in.cross2_real_sum = new_row.cross_re[1];
               rsp_data_in.cross2_imag_sum = new_row.cross_im[1];
               rsp_data_in.cross3_real_sum = new_row.cross_re[2];
               rsp_data_in.cross3_imag_sum = new_row.cross_im[2];
               rsp_data_in.cross4_real_sum = new_row.cross_re[3];
               rsp_data_in.cross4_imag_sum = new_row.cross_im[3];
            end
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         valid_ff   <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      live_ff     <= live_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[work_ff.bin_index] <= new_row;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_row_ff <= mem[q_head.bin_index];
      end
   end

   assign rsp_bus.valid = rsp_vld_ff;
   assign rsp_bus.data  = rsp_data_ff;

endmodule

@@ rtl/csa_checker.sv @@
`include "cross_spectrum_accumulator_top_defines.svh"

module csa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [6:0]  out_bin,
   input logic [46:0] ref_power_sum
);

   `CSA_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_bin) && $stable(ref_power_sum)), "response word changed while stalled")

   `CSA_ASSERT_ALWAYS(a_reset_state, (reset |=> req_ready && !rsp_valid), "block not empty after reset")

   `CSA_ASSERT_ALWAYS(a_min_latency, ($rose(rsp_valid) |-> !$past(reset, 1) && !$past(reset, 2) && !$past(reset, 3) && !$past(reset, 4)), "response too soon after reset")

   `CSA_ASSERT(a_req_known, (req_valid |-> !$isunknown(req_ready)), "req_ready unknown")

endmodule

bind cross_spectrum_accumulator_top csa_checker u_csa_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .out_bin       (rsp_bus.data.out_bin),
   .ref_power_sum (rsp_bus.data.ref_power_sum)
);
